[hdl/lmrs_pkg.sv]
// Types, constants and chip map shared by the LED matrix row-scan packer.
`default_nettype none
package lmrs_pkg;

  localparam logic [31:0] RESET_WORD = 32'hFF00FF00;
  localparam int          MAP_PAIRS  = 6;
  localparam int          GS_BITS    = 12;
  localparam int          DC_BITS    = 6;
  localparam int          SHIFT_BITS = 192;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  localparam logic PHASE_GS = 1'b0;
  localparam logic PHASE_DC = 1'b1;

  typedef enum logic [1:0] {
    CLR_RED   = 2'd0,
    CLR_GREEN = 2'd1,
    CLR_BLUE  = 2'd2
  } colour_t;

  typedef struct packed {
    logic [4:0] base;
    colour_t    colour;
  } map_entry_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  write_row;
    logic [4:0]  write_column;
    logic [31:0] pixel_word;
  } in_item_t;

  typedef struct packed {
    logic        phase;
    logic [2:0]  chip_pair;
    logic [63:0] bits_upper;
    logic [63:0] bits_middle;
    logic [63:0] bits_lower;
    logic [2:0]  row_select;
    logic [15:0] frame_number;
    logic        last;
  } out_item_t;

  // Accumulator control, aligned with the registered read data
  typedef struct packed {
    logic    clear;
    logic    shift;
    logic    phase;
    colour_t colour;
  } acc_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_READ  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_PUSH  = 3'd4
  } state_t;

  // Base column and color of each chip of a pair; first chip fills the upper half
  function automatic map_entry_t chip_map(input logic [2:0] pair, input logic chip);
    map_entry_t e;
    e = '{base: 5'd0, colour: CLR_RED};
    case ({pair, chip})
      4'b000_0: e = '{base: 5'd0,  colour: CLR_GREEN};
      4'b000_1: e = '{base: 5'd0,  colour: CLR_RED};
      4'b001_0: e = '{base: 5'd8,  colour: CLR_RED};
      4'b001_1: e = '{base: 5'd0,  colour: CLR_BLUE};
      4'b010_0: e = '{base: 5'd8,  colour: CLR_BLUE};
      4'b010_1: e = '{base: 5'd8,  colour: CLR_GREEN};
      4'b011_0: e = '{base: 5'd16, colour: CLR_GREEN};
      4'b011_1: e = '{base: 5'd16, colour: CLR_RED};
      4'b100_0: e = '{base: 5'd24, colour: CLR_RED};
      4'b100_1: e = '{base: 5'd16, colour: CLR_BLUE};
      4'b101_0: e = '{base: 5'd24, colour: CLR_BLUE};
      4'b101_1: e = '{base: 5'd24, colour: CLR_GREEN};
      default:  e = '{base: 5'd0,  colour: CLR_RED};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

[hdl/lmrs_store.sv]
// Pixel word store: one write port, one read port with registered data.
`default_nettype none
module lmrs_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/lmrs_acc.sv]
// Shift word accumulator: picks a field from each read word and shifts it in.
`default_nettype none
module lmrs_acc (
  input  wire logic                           clk,
  input  wire lmrs_pkg::acc_ctl_t             ctl,
  input  wire logic [31:0]                    rdata,
  output logic      [lmrs_pkg::SHIFT_BITS-1:0] acc
);
  import lmrs_pkg::*;

  logic [SHIFT_BITS-1:0] acc_r;
  logic [SHIFT_BITS-1:0] acc_nxt;
  logic [7:0]            colour_byte;
  logic [GS_BITS-1:0]    gs_val;
  logic [DC_BITS-1:0]    dc_val;

  always_comb begin
    case (ctl.colour)
      CLR_RED:   colour_byte = rdata[23:16];
      CLR_GREEN: colour_byte = rdata[15:8];
      CLR_BLUE:  colour_byte = rdata[7:0];
      default:   colour_byte = 8'd0;
    endcase
    gs_val = {colour_byte, 4'b0000};
    dc_val = rdata[29:24];
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      if (ctl.phase == PHASE_GS) begin
        acc_nxt = {acc_r[SHIFT_BITS-GS_BITS-1:0], gs_val};
      end else begin
        // dot words start from zero, so 16 shifts leave the upper 96 bits clear
        acc_nxt = {acc_r[SHIFT_BITS-DC_BITS-1:0], dc_val};
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

[hdl/lmrs_ctrl.sv]
// Scan sequencer: store clearing, write handling, read sequencing and result register.
`default_nettype none
module lmrs_ctrl #(
  parameter int ROWS          = 8,
  parameter int WORDS_PER_ROW = 32,
  parameter int CHIP_PAIRS    = 6,
  parameter int DEPTH         = 256,
  parameter int AW            = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lmrs_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lmrs_pkg::out_item_t                  out_data,
  output logic                                 mem_we,
  output logic      [AW-1:0]                   mem_waddr,
  output logic      [31:0]                     mem_wdata,
  output logic                                 mem_re,
  output logic      [AW-1:0]                   mem_raddr,
  output lmrs_pkg::acc_ctl_t                   acc_ctl,
  input  wire logic [lmrs_pkg::SHIFT_BITS-1:0] acc
);
  import lmrs_pkg::*;

  localparam int         RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int         CW         = $clog2(WORDS_PER_ROW);
  localparam int         PAIRS_USED = (CHIP_PAIRS < MAP_PAIRS) ? CHIP_PAIRS : MAP_PAIRS;
  localparam logic [2:0] LAST_PAIR  = 3'(PAIRS_USED - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [3:0]    pix_r;
  logic [2:0]    pair_r;
  logic          phase_r;
  logic [RW-1:0] row_r;
  logic [15:0]   frame_r;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          shift_r;
  logic          shift_phase_r;
  colour_t       shift_colour_r;

  logic          in_fire;
  logic          slot_free;
  logic          push;
  logic          word_last;
  logic          wr_ok;
  map_entry_t    entry;
  logic [4:0]    col;
  logic [RW-1:0] wr_row;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign word_last = (phase_r == PHASE_DC) && (pair_r == LAST_PAIR);
  assign push      = (state_r == ST_PUSH) && slot_free;
  assign wr_ok     = (32'(in_data.write_row) < 32'(ROWS)) &&
                     (32'(in_data.write_column) < 32'(WORDS_PER_ROW));
  assign wr_row    = RW'(in_data.write_row);

  // chip = pix[3], pixel j = pix[2:0]; column runs base+7 down to base
  assign entry = chip_map(pair_r, pix_r[3]);
  assign col   = 5'(entry.base + 5'd7 - {2'b00, pix_r[2:0]});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire && in_data.kind == KIND_SCAN) state_nxt = ST_READ;
      ST_READ:  if (pix_r == 4'd15) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (slot_free) begin
          state_nxt = word_last ? ST_IDLE : ST_READ;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = AW'({wr_row, CW'(in_data.write_column)});
    mem_wdata = in_data.pixel_word;
    mem_re    = 1'b0;
    mem_raddr = AW'({row_r, CW'(col)});
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = RESET_WORD;
      end
      ST_IDLE: begin
        mem_we = in_valid && in_data.kind == KIND_WRITE && wr_ok;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign acc_ctl = '{clear: push, shift: shift_r, phase: shift_phase_r,
                     colour: shift_colour_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pix_r       <= '0;
      pair_r      <= '0;
      phase_r     <= PHASE_GS;
      row_r       <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
      shift_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      shift_r <= mem_re;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == ST_READ) begin
        pix_r <= pix_r + 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
        if (pair_r == LAST_PAIR) begin
          pair_r  <= '0;
          phase_r <= ~phase_r;
        end else begin
          pair_r <= pair_r + 1'b1;
        end
        if (word_last) begin
          if (row_r == LAST_ROW) begin
            row_r   <= '0;
            frame_r <= frame_r + 1'b1;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_phase_r  <= phase_r;
    shift_colour_r <= entry.colour;
    if (push) begin
      out_data_r.phase        <= phase_r;
      out_data_r.chip_pair    <= pair_r;
      out_data_r.bits_upper   <= acc[191:128];
      out_data_r.bits_middle  <= acc[127:64];
      out_data_r.bits_lower   <= acc[63:0];
      out_data_r.row_select   <= 3'(row_r);
      out_data_r.frame_number <= frame_r;
      out_data_r.last         <= word_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no accumulator activity may be pending while a new item can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !acc_ctl.shift)
    else $error("read in flight while ready");

  // a result is only loaded out of the push step
  a_load_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PUSH))
    else $error("result loaded outside push");

  // the row advances exactly when the final word of a row is loaded
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && word_last && row_r != LAST_ROW) |=> (row_r == $past(row_r) + 1'b1))
    else $error("row did not advance");

  // each shift word gathers sixteen reads before it is pushed
  a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (pix_r == 4'd0 && $past(state_r == ST_READ)))
    else $error("drain without full read burst");

endmodule
`default_nettype wire

[hdl/led_matrix_row_scan_packer.sv]
// Top level of the LED matrix row-scan packer: store, sequencer and accumulator.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in_      | input     | in_valid / in_ready  | in_data  (lmrs_pkg::in_item_t)
//  out_     | output    | out_valid / out_ready| out_data (lmrs_pkg::out_item_t)
//
// A write item is taken in the idle state. A scan item builds 12 shift words, each
// from 16 store reads through the single read port, then a drain step and a push
// step; the push waits while the result register is stalled by out_ready.
// After reset a clearing pass writes 0xFF00FF00 to all ROWS*2^clog2(WORDS_PER_ROW)
// entries, one per cycle (256 entries by default); in_ready stays low meanwhile.
// The result register lets the next item be accepted while the last word waits.
`default_nettype none
module led_matrix_row_scan_packer #(
  parameter int ROWS          = 8,
  parameter int WORDS_PER_ROW = 32,
  parameter int CHIP_PAIRS    = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lmrs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lmrs_pkg::out_item_t      out_data
);
  import lmrs_pkg::*;

  localparam int CW    = $clog2(WORDS_PER_ROW);
  localparam int DEPTH = ROWS * (2 ** CW);
  localparam int AW    = $clog2(DEPTH);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [31:0]           mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [31:0]           mem_rdata;
  acc_ctl_t              acc_ctl;
  logic [SHIFT_BITS-1:0] acc;

  lmrs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lmrs_acc u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .rdata (mem_rdata),
    .acc   (acc)
  );

  lmrs_ctrl #(
    .ROWS          (ROWS),
    .WORDS_PER_ROW (WORDS_PER_ROW),
    .CHIP_PAIRS    (CHIP_PAIRS),
    .DEPTH         (DEPTH),
    .AW            (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .acc_ctl   (acc_ctl),
    .acc       (acc)
  );

endmodule
`default_nettype wire

[test/shift_word_checker.sv]
// Checker for the row-scan packer: predicts shift words from observed transfers and compares.
module shift_word_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire lmrs_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire lmrs_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       pending_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import lmrs_pkg::*;

  // Base column and color per [pair][chip]; chip 0 lands in the upper half
  localparam int CHIP_BASE [MAP_PAIRS][2] = '{
    '{0, 0}, '{8, 0}, '{8, 8}, '{16, 16}, '{24, 16}, '{24, 24}
  };
  localparam colour_t CHIP_CLR [MAP_PAIRS][2] = '{
    '{CLR_GREEN, CLR_RED}, '{CLR_RED, CLR_BLUE}, '{CLR_BLUE, CLR_GREEN},
    '{CLR_GREEN, CLR_RED}, '{CLR_RED, CLR_BLUE}, '{CLR_BLUE, CLR_GREEN}
  };

  logic [31:0] pixels [8][32];
  logic [2:0]  scan_row;
  logic [15:0] frame_count;
  out_item_t   shift_q [$];
  out_item_t   want;

  // Build the six grayscale words, then the six dot-correction words, of the current row
  task automatic predict_scan();
    logic [191:0] acc;
    logic [31:0]  w;
    logic [7:0]   gray;
    out_item_t    word;
    for (int ph = 0; ph < 2; ph++) begin
      for (int p = 0; p < MAP_PAIRS; p++) begin
        acc = '0;
        for (int c = 0; c < 2; c++) begin
          for (int j = 0; j < 8; j++) begin
            w = pixels[scan_row][CHIP_BASE[p][c] + 7 - j];
            if (ph == 0) begin
              case (CHIP_CLR[p][c])
                CLR_RED:   gray = w[23:16];
                CLR_GREEN: gray = w[15:8];
                default:   gray = w[7:0];
              endcase
              acc = {acc[179:0], gray, 4'h0};
            end else begin
              acc = {acc[185:0], w[29:24]};
            end
          end
        end
        word.phase        = (ph == 0) ? PHASE_GS : PHASE_DC;
        word.chip_pair    = 3'(p);
        word.bits_upper   = acc[191:128];
        word.bits_middle  = acc[127:64];
        word.bits_lower   = acc[63:0];
        word.row_select   = scan_row;
        word.frame_number = frame_count;
        word.last         = (ph == 1) && (p == MAP_PAIRS - 1);
        shift_q.push_back(word);
      end
    end
    if (scan_row == 3'd7) begin
      frame_count = frame_count + 16'd1;
    end
    scan_row = scan_row + 3'd1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 8; r++) begin
        for (int c = 0; c < 32; c++) begin
          pixels[r][c] = RESET_WORD;
        end
      end
      scan_row    = '0;
      frame_count = '0;
      fail_count  = 0;
      shift_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (shift_q.size() == 0) begin
          $error("unexpected shift word %h", out_data);
          fail_count++;
        end else begin
          want = shift_q.pop_front();
          if (out_data.phase !== want.phase) begin
            $error("phase expected %0h got %0h", want.phase, out_data.phase);
            fail_count++;
          end
          if (out_data.chip_pair !== want.chip_pair) begin
            $error("chip_pair expected %0h got %0h", want.chip_pair, out_data.chip_pair);
            fail_count++;
          end
          if (out_data.bits_upper !== want.bits_upper) begin
            $error("bits_upper expected %h got %h", want.bits_upper, out_data.bits_upper);
            fail_count++;
          end
          if (out_data.bits_middle !== want.bits_middle) begin
            $error("bits_middle expected %h got %h", want.bits_middle, out_data.bits_middle);
            fail_count++;
          end
          if (out_data.bits_lower !== want.bits_lower) begin
            $error("bits_lower expected %h got %h", want.bits_lower, out_data.bits_lower);
            fail_count++;
          end
          if (out_data.row_select !== want.row_select) begin
            $error("row_select expected %0h got %0h", want.row_select, out_data.row_select);
            fail_count++;
          end
          if (out_data.frame_number !== want.frame_number) begin
            $error("frame_number expected %0h got %0h", want.frame_number,
                   out_data.frame_number);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last expected %0h got %0h", want.last, out_data.last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_WRITE) begin
          pixels[in_data.write_row][in_data.write_column] = in_data.pixel_word;
        end else begin
          predict_scan();
        end
      end
    end
    pending_words <= shift_q.size();
  end

endmodule

[test/led_matrix_row_scan_packer_tb.sv]
// Testbench top for the row-scan packer: stimulus, receiver stalls, timeout and verdict.
module led_matrix_row_scan_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lmrs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending_words;
  int cycle_count = 0;
  int stall_left = 0;
  int scans_sent = 0;
  bit tx_steady = 1'b1;
  bit rx_steady = 1'b1;

  led_matrix_row_scan_packer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  shift_word_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(in_item_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.kind == KIND_SCAN) begin
      scans_sent++;
    end
    gap = (tx_steady || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(logic [2:0] row, logic [4:0] col, logic [31:0] word);
    in_item_t item;
    item.kind         = KIND_WRITE;
    item.write_row    = row;
    item.write_column = col;
    item.pixel_word   = word;
    send_item(item);
  endtask

  // Address and data fields of a scan carry noise; the block must ignore them
  task automatic send_scan();
    in_item_t item;
    item.kind         = KIND_SCAN;
    item.write_row    = 3'($urandom);
    item.write_column = 5'($urandom);
    item.pixel_word   = $urandom;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] word;
    int          r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset contents first, then corner words, then a full frame plus the wrap
    send_scan();
    send_write(3'd1, 5'd0, 32'hFFFF_FFFF);
    send_write(3'd1, 5'd31, 32'h0000_0000);
    send_write(3'd1, 5'd7, 32'h3F12_3456);
    send_write(3'd1, 5'd8, 32'hC000_0000);  // only the never-used top bits set
    send_write(3'd1, 5'd15, 32'h2AA5_A5A5);
    send_write(3'd7, 5'd31, 32'hFFFF_FFFF);
    send_write(3'd7, 5'd0, 32'h0000_0000);
    send_write(3'd0, 5'd0, 32'h00FF_FFFF);
    for (int i = 0; i < 8; i++) begin
      send_scan();
    end
    send_scan();
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      tx_steady = (ph == 0) || (ph == 4);
      rx_steady = (ph == 0) || (ph == 2);
      for (int i = 0; i < 25; i++) begin
        r = $urandom_range(0, 99);
        if (r < 22) begin
          send_scan();
        end else begin
          case ($urandom_range(0, 7))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            default: word = $urandom;
          endcase
          // Bias writes toward the row that the next scan will pack
          send_write((r < 65) ? 3'(scans_sent) : 3'($urandom_range(0, 7)),
                     5'($urandom_range(0, 31)), word);
        end
      end
      if (ph == 3) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (250) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
